// ===== rtl/ilist_pkg.sv =====
// Shared types, constants and codes for the indexed insert/remove list.
package ilist_pkg;

    localparam int WORD_W           = 64;
    localparam int POS_W            = 8;
    localparam int CMD_W            = 3;
    localparam int COUNT_W          = 7;
    localparam int STAT_W           = 2;
    localparam int DEFAULT_CAPACITY = 64;
    // Index width at the largest supported capacity (1024 entries).
    localparam int MAX_IDX_W        = 10;

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND = 3'd0,
        CMD_INSERT = 3'd1,
        CMD_REMOVE = 3'd2,
        CMD_SWAP   = 3'd3,
        CMD_READ   = 3'd4,
        CMD_LENGTH = 3'd5,
        CMD_CLEAR  = 3'd6
    } cmd_t;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_INSERT,
        OP_REMOVE,
        OP_SWAP
    } op_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RESOLVE,
        S_READ,
        S_COMMIT
    } state_t;

    typedef struct packed {
        op_t                  op;
        logic [MAX_IDX_W-1:0] idx_a;
        logic [MAX_IDX_W-1:0] idx_b;
    } cell_ctrl_t;

endpackage

// ===== rtl/ilist_req_if.sv =====
// Command channel interface: valid/ready handshake plus command payload.
interface ilist_req_if;
    logic                               valid;
    logic                               ready;
    logic [ilist_pkg::CMD_W-1:0]        cmd;
    logic signed [ilist_pkg::POS_W-1:0] pos_a;
    logic signed [ilist_pkg::POS_W-1:0] pos_b;
    logic [ilist_pkg::WORD_W-1:0]       new_value;

    modport source (output valid, cmd, pos_a, pos_b, new_value, input ready);
    modport sink   (input valid, cmd, pos_a, pos_b, new_value, output ready);
endinterface

// ===== rtl/ilist_rsp_if.sv =====
// Response channel interface: valid/ready handshake plus result payload.
interface ilist_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [ilist_pkg::WORD_W-1:0]  value;
    logic [ilist_pkg::COUNT_W-1:0] item_count;
    logic [ilist_pkg::STAT_W-1:0]  status;

    modport source (output valid, value, item_count, status, input ready);
    modport sink   (input valid, value, item_count, status, output ready);
endinterface

// ===== rtl/ilist_cell.sv =====
// One list cell: holds a single entry and shifts, loads or swaps it.
module ilist_cell #(
    parameter int CELL_IDX = 0
) (
    input  logic                            clk,
    input  ilist_pkg::cell_ctrl_t           ctrl,
    input  logic [ilist_pkg::WORD_W-1:0]    word,
    input  logic [ilist_pkg::WORD_W-1:0]    rd_a,
    input  logic [ilist_pkg::WORD_W-1:0]    rd_b,
    input  logic [ilist_pkg::WORD_W-1:0]    left_data,
    input  logic [ilist_pkg::WORD_W-1:0]    right_data,
    output logic [ilist_pkg::WORD_W-1:0]    data
);

    localparam logic [ilist_pkg::MAX_IDX_W-1:0] MY_IDX = ilist_pkg::MAX_IDX_W'(CELL_IDX);

    logic [ilist_pkg::WORD_W-1:0] data_reg;
    logic [ilist_pkg::WORD_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        unique case (ctrl.op)
            ilist_pkg::OP_INSERT:
            begin
                if (MY_IDX == ctrl.idx_a)
                    data_next = word;
                else if (MY_IDX > ctrl.idx_a)
                    data_next = left_data;
            end
            ilist_pkg::OP_REMOVE:
            begin
                if (MY_IDX >= ctrl.idx_a)
                    data_next = right_data;
            end
            ilist_pkg::OP_SWAP:
            begin
                if (MY_IDX == ctrl.idx_a)
                    data_next = rd_b;
                else if (MY_IDX == ctrl.idx_b)
                    data_next = rd_a;
            end
            default: data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// ===== rtl/indexed_insert_remove_list.sv =====
// Indexed insert/remove list: a row of cells holding up to CAPACITY 64-bit words.
// A command passes through resolve, read and commit in order, and the response register is
// loaded at commit. The resolve/read/commit sequencer handles one command at a time, and
// commit waits while the response register is still held.
// Reset: rst_n clears the sequencer, the length and the response valid; cell contents
// are not reset and stay undefined until written.
module indexed_insert_remove_list #(
    parameter int CAPACITY = ilist_pkg::DEFAULT_CAPACITY
) (
    input  logic         clk,
    input  logic         rst_n,
    ilist_req_if.sink    req,
    ilist_rsp_if.source  rsp
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int LEN_W = $clog2(CAPACITY + 1);
    // Signed width wide enough for a sign-extended position plus the length.
    localparam int RW    = ((LEN_W > ilist_pkg::POS_W) ? LEN_W : ilist_pkg::POS_W) + 2;
    localparam int EXT_W = LEN_W + ilist_pkg::COUNT_W;
    localparam logic [LEN_W-1:0] CAP_LEN = LEN_W'(CAPACITY);

    // Sequencer and captured command
    ilist_pkg::state_t                  state_reg, state_next;
    ilist_pkg::cmd_t                    cmd_reg;
    logic signed [ilist_pkg::POS_W-1:0] pos_a_reg, pos_b_reg;
    logic [ilist_pkg::WORD_W-1:0]       word_reg;

    // Resolved operation
    ilist_pkg::op_t                     op_reg, op_next;
    logic [IDX_W-1:0]                   idx_a_reg, idx_a_next;
    logic [IDX_W-1:0]                   idx_b_reg, idx_b_next;
    logic [ilist_pkg::STAT_W-1:0]       status_reg, status_next;
    logic                               read_reg, read_next;
    logic                               clear_reg, clear_next;

    // Read-out of the addressed cells
    logic [ilist_pkg::WORD_W-1:0]       rd_a_reg, rd_a_next;
    logic [ilist_pkg::WORD_W-1:0]       rd_b_reg, rd_b_next;

    logic [LEN_W-1:0]                   length_reg, length_next;

    // Response register
    logic                               out_valid_reg, out_valid_next;
    logic [ilist_pkg::WORD_W-1:0]       out_value_reg, out_value_next;
    logic [ilist_pkg::COUNT_W-1:0]      out_count_reg, out_count_next;
    logic [ilist_pkg::STAT_W-1:0]       out_status_reg, out_status_next;

    logic                               req_fire;
    logic                               commit_fire;
    ilist_pkg::cell_ctrl_t              cell_ctrl;
    logic [ilist_pkg::WORD_W-1:0]       cell_data [CAPACITY];

    // Position normalization
    logic signed [RW-1:0]               len_s;
    logic signed [RW-1:0]               pa_s, pb_s;
    logic                               pa_ok, pa_ok_end, pb_ok;
    logic                               full;
    logic [EXT_W-1:0]                   len_ext;

    function automatic logic signed [RW-1:0] norm_pos(
        input logic signed [ilist_pkg::POS_W-1:0] pos,
        input logic signed [RW-1:0]               len
    );
        logic signed [RW-1:0] p;
        p = RW'(pos);
        if (pos < 0)
            p = p + len;
        return p;
    endfunction

    assign req_fire    = req.valid && req.ready;
    assign req.ready   = (state_reg == ilist_pkg::S_IDLE);
    assign commit_fire = (state_reg == ilist_pkg::S_COMMIT) && (!out_valid_reg || rsp.ready);

    assign len_s     = signed'(RW'(length_reg));
    assign pa_s      = norm_pos(pos_a_reg, len_s);
    assign pb_s      = norm_pos(pos_b_reg, len_s);
    assign pa_ok     = (pa_s >= 0) && (pa_s < len_s);
    assign pa_ok_end = (pa_s >= 0) && (pa_s <= len_s);
    assign pb_ok     = (pb_s >= 0) && (pb_s < len_s);
    assign full      = (length_reg == CAP_LEN);

    // Resolve: decide the operation and its status from the captured command
    always_comb
    begin
        op_next     = ilist_pkg::OP_NONE;
        idx_a_next  = pa_s[IDX_W-1:0];
        idx_b_next  = pb_s[IDX_W-1:0];
        status_next = ilist_pkg::STAT_OK;
        read_next   = 1'b0;
        clear_next  = 1'b0;
        unique case (cmd_reg)
            ilist_pkg::CMD_APPEND:
            begin
                idx_a_next = length_reg[IDX_W-1:0];
                if (full)
                    status_next = ilist_pkg::STAT_FULL;
                else
                    op_next = ilist_pkg::OP_INSERT;
            end
            ilist_pkg::CMD_INSERT:
            begin
                if (!pa_ok_end)
                    status_next = ilist_pkg::STAT_RANGE;
                else if (full)
                    status_next = ilist_pkg::STAT_FULL;
                else
                    op_next = ilist_pkg::OP_INSERT;
            end
            ilist_pkg::CMD_REMOVE:
            begin
                if (!pa_ok)
                    status_next = ilist_pkg::STAT_RANGE;
                else
                begin
                    op_next   = ilist_pkg::OP_REMOVE;
                    read_next = 1'b1;
                end
            end
            ilist_pkg::CMD_SWAP:
            begin
                if (!pa_ok || !pb_ok)
                    status_next = ilist_pkg::STAT_RANGE;
                else
                    op_next = ilist_pkg::OP_SWAP;
            end
            ilist_pkg::CMD_READ:
            begin
                if (!pa_ok)
                    status_next = ilist_pkg::STAT_RANGE;
                else
                    read_next = 1'b1;
            end
            ilist_pkg::CMD_CLEAR: clear_next = 1'b1;
            default: ; // length query and the unused code change nothing
        endcase
    end

    // Read: select the two addressed cells (one-hot OR across the row)
    always_comb
    begin
        rd_a_next = '0;
        rd_b_next = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (idx_a_reg == IDX_W'(i))
                rd_a_next = rd_a_next | cell_data[i];
            if (idx_b_reg == IDX_W'(i))
                rd_b_next = rd_b_next | cell_data[i];
        end
    end

    // Commit: update length and build the response
    always_comb
    begin
        length_next = length_reg;
        if (clear_reg)
            length_next = '0;
        else if (op_reg == ilist_pkg::OP_INSERT)
            length_next = length_reg + LEN_W'(1);
        else if (op_reg == ilist_pkg::OP_REMOVE)
            length_next = length_reg - LEN_W'(1);
    end

    assign len_ext = EXT_W'(length_next);

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_value_next  = out_value_reg;
        out_count_next  = out_count_reg;
        out_status_next = out_status_reg;
        if (commit_fire)
        begin
            out_valid_next  = 1'b1;
            out_value_next  = read_reg ? rd_a_reg : '0;
            out_count_next  = len_ext[ilist_pkg::COUNT_W-1:0];
            out_status_next = status_reg;
        end
        else if (rsp.ready)
            out_valid_next = 1'b0;
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ilist_pkg::S_IDLE:    if (req_fire) state_next = ilist_pkg::S_RESOLVE;
            ilist_pkg::S_RESOLVE: state_next = ilist_pkg::S_READ;
            ilist_pkg::S_READ:    state_next = ilist_pkg::S_COMMIT;
            ilist_pkg::S_COMMIT:  if (commit_fire) state_next = ilist_pkg::S_IDLE;
            default:              state_next = ilist_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ilist_pkg::S_IDLE;
            length_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (commit_fire)
                length_reg <= length_next;
        end
    end

    // Payload registers: hold the captured command and intermediate results
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            cmd_reg   <= ilist_pkg::cmd_t'(req.cmd);
            pos_a_reg <= req.pos_a;
            pos_b_reg <= req.pos_b;
            word_reg  <= req.new_value;
        end
        if (state_reg == ilist_pkg::S_RESOLVE)
        begin
            op_reg     <= op_next;
            idx_a_reg  <= idx_a_next;
            idx_b_reg  <= idx_b_next;
            status_reg <= status_next;
            read_reg   <= read_next;
            clear_reg  <= clear_next;
        end
        if (state_reg == ilist_pkg::S_READ)
        begin
            rd_a_reg <= rd_a_next;
            rd_b_reg <= rd_b_next;
        end
        out_value_reg  <= out_value_next;
        out_count_reg  <= out_count_next;
        out_status_reg <= out_status_next;
    end

    // Drive the cell row only in the commit cycle
    assign cell_ctrl.op    = commit_fire ? op_reg : ilist_pkg::OP_NONE;
    assign cell_ctrl.idx_a = ilist_pkg::MAX_IDX_W'(idx_a_reg);
    assign cell_ctrl.idx_b = ilist_pkg::MAX_IDX_W'(idx_b_reg);

    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic [ilist_pkg::WORD_W-1:0] left_data;
        logic [ilist_pkg::WORD_W-1:0] right_data;

        if (g == 0)
        begin : g_first
            assign left_data = cell_data[g];
        end
        else
        begin : g_mid_l
            assign left_data = cell_data[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_last
            assign right_data = cell_data[g];
        end
        else
        begin : g_mid_r
            assign right_data = cell_data[g+1];
        end

        ilist_cell #(
            .CELL_IDX (g)
        ) u_cell (
            .clk        (clk),
            .ctrl       (cell_ctrl),
            .word       (word_reg),
            .rd_a       (rd_a_reg),
            .rd_b       (rd_b_reg),
            .left_data  (left_data),
            .right_data (right_data),
            .data       (cell_data[g])
        );
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.value      = out_value_reg;
    assign rsp.item_count = out_count_reg;
    assign rsp.status     = out_status_reg;

endmodule

// ===== rtl/ilist_checker.sv =====
// Port-level checker for the indexed insert/remove list, with its bind.
module ilist_checker #(
    parameter int CAPACITY = ilist_pkg::DEFAULT_CAPACITY
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          req_valid,
    input logic                          req_ready,
    input logic                          rsp_valid,
    input logic                          rsp_ready,
    input logic [ilist_pkg::WORD_W-1:0]  value,
    input logic [ilist_pkg::COUNT_W-1:0] item_count,
    input logic [ilist_pkg::STAT_W-1:0]  status
);

    localparam logic [ilist_pkg::COUNT_W-1:0] CAP_COUNT = ilist_pkg::COUNT_W'(CAPACITY);

    // A pending response holds until taken
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(value) && $stable(status))
        else $error("response dropped or changed while stalled");

    // One command in flight: no accept right after an accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("command accepted while another is in flight");

    // A failed command returns a zero word
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status != ilist_pkg::STAT_OK) |-> value == '0)
        else $error("nonzero value on failed command");

    // Full status only when the list holds CAPACITY entries
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == ilist_pkg::STAT_FULL) |-> item_count == CAP_COUNT)
        else $error("full status with short list");

endmodule

bind indexed_insert_remove_list ilist_checker #(
    .CAPACITY (CAPACITY)
) u_ilist_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .value      (rsp.value),
    .item_count (rsp.item_count),
    .status     (rsp.status)
);
